/* src/ovl_pkg.sv */
// ----------------------------------------------------------------------------
// ovl_pkg
// Shared types and codes of the ordered value list engine: operation codes,
// result status codes, field widths and the sequencer states.
// ----------------------------------------------------------------------------
package ovl_pkg;

	localparam int OP_W     = 3;
	localparam int VALUE_W  = 32;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 6;

	// operation codes; codes 6 and 7 are unused and act as a no-op
	typedef enum logic [OP_W-1:0] {
		OP_PUSH_FRONT  = 3'd0,
		OP_APPEND      = 3'd1,
		OP_INSERT_AFTER = 3'd2,
		OP_DEL_FIRST   = 3'd3,
		OP_DEL_LAST    = 3'd4,
		OP_DUMP        = 3'd5
	} op_t;

	// result status codes
	typedef enum logic [STATUS_W-1:0] {
		STAT_OK      = 2'd0,
		STAT_MISSING = 2'd1,
		STAT_FULL    = 2'd2,
		STAT_EMPTY   = 2'd3
	} status_t;

	// sequencer states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SCAN_RD,
		ST_SCAN_CHK,
		ST_UP_RD,
		ST_UP_WR,
		ST_DN_RD,
		ST_DN_WR,
		ST_PUT,
		ST_DUMP_RD,
		ST_DUMP_EMIT,
		ST_REPORT
	} state_t;

endpackage

/* src/ovl_stream_if.sv */
// ----------------------------------------------------------------------------
// ovl_stream_if
// Valid/ready channels of the ordered value list engine: the operation
// channel (ovl_in_if) and the result channel (ovl_out_if).
// ----------------------------------------------------------------------------
interface ovl_in_if import ovl_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic [OP_W-1:0]            op;
	logic signed [VALUE_W-1:0]  operand_value;
	logic signed [VALUE_W-1:0]  insert_value;

	modport source (output valid, op, operand_value, insert_value, input ready);
	modport sink   (input valid, op, operand_value, insert_value, output ready);
endinterface

interface ovl_out_if import ovl_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic [STATUS_W-1:0]        status;
	logic [COUNT_W-1:0]         entry_count;
	logic signed [VALUE_W-1:0]  entry_value;
	logic                       last_of_run;

	modport source (output valid, status, entry_count, entry_value, last_of_run,
		input ready);
	modport sink   (input valid, status, entry_count, entry_value, last_of_run,
		output ready);
endinterface

/* src/ovl_ram.sv */
// ----------------------------------------------------------------------------
// ovl_ram
// Generic single-clock RAM: one write port, one read port, registered read
// data that holds while no read is issued.
// ----------------------------------------------------------------------------
module ovl_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                      clk,
	input  logic                      we,
	input  logic [$clog2(DEPTH)-1:0]  waddr,
	input  logic [WIDTH-1:0]          wdata,
	input  logic                      re,
	input  logic [$clog2(DEPTH)-1:0]  raddr,
	output logic [WIDTH-1:0]          rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* src/ordered_value_list_engine_top.sv */
// Operations: push front shifts every entry up one place, insert and
//   delete scan the entries and then shift, append writes once, and a
//   dump reads and emits the entries one by one.
// Throughput: one operation at a time; the single RAM read port and the
//   read-then-write walk over the entries set the rate.
// Reset: arst_n clears the length and the control state; no RAM clear pass.
// ----------------------------------------------------------------------------
// ordered_value_list_engine_top
// Ordered list of signed 32-bit values held packed, front first, in one
// synchronous RAM. A sequencer scans, shifts and dumps entries one RAM
// access per cycle and reports through a registered result stage.
// ----------------------------------------------------------------------------
module ordered_value_list_engine_top import ovl_pkg::*; #(
	parameter int LIST_DEPTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	ovl_in_if.sink      req,
	ovl_out_if.source   rsp
);

	localparam int IW = $clog2(LIST_DEPTH + 1);
	localparam int AW = $clog2(LIST_DEPTH);

	state_t               state_q, state_nxt;
	op_t                  op_q;
	status_t              status_q;
	logic [VALUE_W-1:0]   key_q;
	logic [VALUE_W-1:0]   put_q;
	logic [IW-1:0]        idx_q;
	logic [IW-1:0]        pos_q;
	logic [IW-1:0]        len_q;
	logic                 found_q;

	logic                 out_valid_q;
	status_t              out_status_q;
	logic [COUNT_W-1:0]   out_count_q;
	logic [VALUE_W-1:0]   out_value_q;
	logic                 out_last_q;

	logic                 ram_we, ram_re;
	logic [AW-1:0]        ram_waddr, ram_raddr;
	logic [VALUE_W-1:0]   ram_wdata, ram_rdata;

	logic                 accept, out_free, out_load;
	logic                 is_full, is_empty, match, at_end;
	logic                 del_hit, del_more, len_drop;
	logic [IW-1:0]        idx_inc, idx_inc2, idx_dec, del_pos, del_pos_inc;
	logic [IW+COUNT_W-1:0] len_wide;
	op_t                  in_op;

	ovl_ram #(
		.WIDTH (VALUE_W),
		.DEPTH (LIST_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// shared conditions
	assign in_op       = op_t'(req.op);
	assign accept      = req.valid && req.ready;
	assign out_free    = !out_valid_q || rsp.ready;
	assign is_full     = len_q >= IW'(LIST_DEPTH);
	assign is_empty    = len_q == '0;
	assign idx_inc     = idx_q + IW'(1);
	assign idx_inc2    = idx_q + IW'(2);
	assign idx_dec     = idx_q - IW'(1);
	assign match       = ram_rdata == key_q;
	assign at_end      = idx_inc == len_q;
	assign del_hit     = (op_q == OP_DEL_FIRST && match) ||
		(op_q == OP_DEL_LAST && at_end && (found_q || match));
	assign del_pos     = (op_q == OP_DEL_LAST && !match) ? pos_q : idx_q;
	assign del_pos_inc = del_pos + IW'(1);
	assign del_more    = del_pos_inc < len_q;
	assign len_drop    = (state_q == ST_SCAN_CHK && del_hit && !del_more) ||
		(state_q == ST_DN_WR && !(idx_inc2 < len_q));
	assign len_wide    = {{COUNT_W{1'b0}}, len_q};

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					unique case (in_op)
						OP_PUSH_FRONT:   state_nxt = is_full ? ST_REPORT :
							(is_empty ? ST_PUT : ST_UP_RD);
						OP_APPEND:       state_nxt = is_full ? ST_REPORT : ST_PUT;
						OP_INSERT_AFTER: state_nxt = (is_full || is_empty) ? ST_REPORT :
							ST_SCAN_RD;
						OP_DEL_FIRST,
						OP_DEL_LAST:     state_nxt = is_empty ? ST_REPORT : ST_SCAN_RD;
						OP_DUMP:         state_nxt = is_empty ? ST_REPORT : ST_DUMP_RD;
						default:         state_nxt = ST_REPORT;
					endcase
				end
			end
			ST_SCAN_RD: state_nxt = ST_SCAN_CHK;
			ST_SCAN_CHK: begin
				priority if (op_q == OP_INSERT_AFTER && match) begin
					state_nxt = (len_q > idx_inc) ? ST_UP_RD : ST_PUT;
				end else if (del_hit) begin
					state_nxt = del_more ? ST_DN_RD : ST_REPORT;
				end else if (at_end) begin
					state_nxt = ST_REPORT;
				end else begin
					state_nxt = ST_SCAN_RD;
				end
			end
			ST_UP_RD: state_nxt = ST_UP_WR;
			ST_UP_WR: state_nxt = (idx_dec > pos_q) ? ST_UP_RD : ST_PUT;
			ST_DN_RD: state_nxt = ST_DN_WR;
			ST_DN_WR: state_nxt = (idx_inc2 < len_q) ? ST_DN_RD : ST_REPORT;
			ST_PUT:   state_nxt = ST_REPORT;
			ST_DUMP_RD: state_nxt = ST_DUMP_EMIT;
			ST_DUMP_EMIT: begin
				if (out_free) begin
					state_nxt = at_end ? ST_IDLE : ST_DUMP_RD;
				end
			end
			ST_REPORT: begin
				if (out_free) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	// RAM and handshake controls; accesses never overlap: no state both
	// reads and writes the RAM
	always_comb begin
		req.ready = 1'b0;
		ram_re    = 1'b0;
		ram_raddr = idx_q[AW-1:0];
		ram_we    = 1'b0;
		ram_waddr = idx_q[AW-1:0];
		ram_wdata = ram_rdata;
		out_load  = 1'b0;
		unique case (state_q)
			ST_IDLE:    req.ready = 1'b1;
			ST_SCAN_RD: ram_re = 1'b1;
			ST_UP_RD: begin
				ram_re    = 1'b1;
				ram_raddr = idx_dec[AW-1:0];
			end
			ST_UP_WR:   ram_we = 1'b1;
			ST_DN_RD: begin
				ram_re    = 1'b1;
				ram_raddr = idx_inc[AW-1:0];
			end
			ST_DN_WR:   ram_we = 1'b1;
			ST_PUT: begin
				ram_we    = 1'b1;
				ram_waddr = pos_q[AW-1:0];
				ram_wdata = put_q;
			end
			ST_DUMP_RD: ram_re = 1'b1;
			ST_DUMP_EMIT,
			ST_REPORT:  out_load = out_free;
			default: ;
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// list length: grow on a final write, shrink when a deletion ends
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
		end else if (state_q == ST_PUT) begin
			len_q <= len_q + IW'(1);
		end else if (len_drop) begin
			len_q <= len_q - IW'(1);
		end
	end

	// operation context and walk index
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					op_q     <= in_op;
					key_q    <= req.operand_value;
					put_q    <= (in_op == OP_INSERT_AFTER) ? req.insert_value :
						req.operand_value;
					idx_q    <= (in_op == OP_PUSH_FRONT) ? len_q : '0;
					pos_q    <= (in_op == OP_APPEND) ? len_q : '0;
					found_q  <= 1'b0;
					unique case (in_op)
						OP_PUSH_FRONT,
						OP_APPEND: begin
							status_q <= is_full ? STAT_FULL : STAT_OK;
						end
						OP_INSERT_AFTER: begin
							status_q <= is_full ? STAT_FULL :
								(is_empty ? STAT_MISSING : STAT_OK);
						end
						OP_DEL_FIRST,
						OP_DEL_LAST: begin
							status_q <= is_empty ? STAT_MISSING : STAT_OK;
						end
						OP_DUMP: begin
							status_q <= is_empty ? STAT_EMPTY : STAT_OK;
						end
						default: status_q <= STAT_OK;
					endcase
				end
			end
			ST_SCAN_CHK: begin
				priority if (op_q == OP_INSERT_AFTER && match) begin
					pos_q <= idx_inc;
					idx_q <= len_q;
				end else if (del_hit) begin
					idx_q <= del_pos;
				end else if (at_end) begin
					status_q <= STAT_MISSING;
				end else begin
					if (match) begin
						found_q <= 1'b1;
						pos_q   <= idx_q;
					end
					idx_q <= idx_inc;
				end
			end
			ST_UP_WR:  idx_q <= idx_dec;
			ST_DN_WR:  idx_q <= idx_inc;
			ST_DUMP_EMIT: begin
				if (out_free) idx_q <= idx_inc;
			end
			default: ;
		endcase
	end

	// result stage: hold a transaction until taken, refill in the same cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_count_q <= len_wide[COUNT_W-1:0];
			if (state_q == ST_DUMP_EMIT) begin
				out_status_q <= STAT_OK;
				out_value_q  <= ram_rdata;
				out_last_q   <= at_end;
			end else begin
				out_status_q <= status_q;
				out_value_q  <= '0;
				out_last_q   <= 1'b1;
			end
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.status      = out_status_q;
	assign rsp.entry_count = out_count_q;
	assign rsp.entry_value = out_value_q;
	assign rsp.last_of_run = out_last_q;

	// checks
	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= IW'(LIST_DEPTH))
		else $error("list length beyond depth");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && !rsp.ready) |=> (rsp.valid && $stable(rsp.entry_value)))
		else $error("pending result overwritten");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !req.ready)
		else $error("new operation taken while one is in progress");

	a_len_changes_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		(len_q != $past(len_q)) |-> (state_q == ST_REPORT))
		else $error("length changed outside completion of an operation");

	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		!(ram_we && ram_re))
		else $error("RAM read and write in the same cycle");

endmodule
